>>> design/bpfa_pkg.sv
// Package for the mosaic five-point average unit: field widths, stream
// layout, register indexes, controller states and the lane control group.
// No dependencies.
`default_nettype none

package bpfa_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_CHANNEL_BITS = 16;

    // Fixed field widths
    localparam int COORD_W     = 8;    // pos_x, pos_y
    localparam int DIM_W       = 9;    // image size and clamped sample coordinates
    localparam int RADIUS_W    = 8;
    localparam int CHAN_W      = 16;   // channel fields on the ports
    localparam int NUM_CHAN    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Stream layout
    localparam int IN_POS_X_LSB = 0;
    localparam int IN_POS_Y_LSB = IN_POS_X_LSB + COORD_W;
    localparam int IN_CHAN_LSB  = IN_POS_Y_LSB + COORD_W;
    localparam int IN_TDATA_W   = IN_CHAN_LSB + NUM_CHAN * CHAN_W;
    localparam int OUT_TDATA_W  = NUM_CHAN * CHAN_W;

    // Remainder divider: bits retired per cycle and cycles per division
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = COORD_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // Operation codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_RADIUS = 2'd2;

    // Read sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CORNER,
        ST_CENTER,
        ST_EDGE,
        ST_FETCH,
        ST_DRAIN,
        ST_SCALE,
        ST_RESULT
    } state_t;

    // Control group from the sequencer to every channel lane
    typedef struct packed {
        logic clear;
        logic accumulate;
        logic scale;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/bpfa_rem_div.sv
// Iterative remainder unit: coordinate modulo mosaic side, several bits a cycle.
// Depends on bpfa_pkg.
`default_nettype none

module bpfa_rem_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bpfa_pkg::COORD_W-1:0] dividend,
    input  wire logic [bpfa_pkg::DIM_W-1:0]   divisor,
    output logic                            done,
    output logic [bpfa_pkg::COORD_W-1:0]    remainder
);
    import bpfa_pkg::*;

    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   dividend_reg, dividend_next;
    logic [DIM_W-1:0]     divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIM_W-1:0]     work;
    logic [COORD_W-1:0]   shift;

    // Retire DIV_STEPS quotient bits: shift in, compare, subtract
    always_comb
    begin
        work  = {1'b0, rem_reg};
        shift = dividend_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            work  = {work[COORD_W-1:0], shift[COORD_W-1]};
            shift = {shift[COORD_W-2:0], 1'b0};
            if (work >= divisor_reg)
            begin
                work = work - divisor_reg;
            end
        end
        rem_next      = work[COORD_W-1:0];
        dividend_next = shift;
    end

    // Count remaining steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_CYCLES);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Hold operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= '0;
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg      <= rem_next;
            dividend_reg <= dividend_next;
        end
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/bpfa_chan_lane.sv
// One channel lane: accumulates the five samples and divides by five with
// rounding through a reciprocal multiply. Depends on bpfa_pkg.
`default_nettype none

module bpfa_chan_lane #(
    parameter int STORE_BITS = bpfa_pkg::CHAN_W
) (
    input  wire logic                   clk,
    input  wire bpfa_pkg::lane_ctrl_t   ctrl,
    input  wire logic [STORE_BITS-1:0]  sample,
    output logic [STORE_BITS-1:0]       avg
);
    import bpfa_pkg::*;

    // Five samples plus rounding fit in three extra bits
    localparam int SUM_W     = STORE_BITS + 3;
    localparam int SHIFT     = SUM_W + 2;
    localparam int RECIP_INT = (1 << SHIFT) / 5 + 1;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'(RECIP_INT);

    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [2*SUM_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]   rounded;

    // Clear at request start, add each sample as it returns
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.accumulate)
        begin
            acc_next = acc_reg + SUM_W'(sample);
        end
    end

    // (sum + 2) / 5 as multiply by rounded-up reciprocal and shift
    always_comb
    begin
        rounded   = acc_reg + SUM_W'(2);
        prod_next = prod_reg;
        if (ctrl.scale)
        begin
            prod_next = (2*SUM_W)'(rounded) * (2*SUM_W)'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign avg = prod_reg[SHIFT +: STORE_BITS];

endmodule

`default_nettype wire

>>> design/bpfa_frame_mem.sv
// Single-port frame store with registered read data.
// Depends on nothing but the parameters handed down from the top level.
`default_nettype none

module bpfa_frame_mem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/block_pixelate_five_point_average_unit.sv
// Top level of the mosaic five-point average unit: config registers, read
// sequencer, frame store, coordinate dividers, four channel lanes and the merging
// output register. Uses bpfa_pkg, bpfa_rem_div, bpfa_chan_lane and bpfa_frame_mem.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid / tready        tuser: operation; tdata: coords, 4 channels
// m_axis   out  tvalid / tready        tuser: outside_frame; tdata: 4 averages
// cfg      in   cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
// A load in range is written to the frame store as it is accepted. An inside read
// runs the remainder dividers, then corner, center and edge coordinates, then the
// five single-port frame store fetches, then drain, scale and result. An outside
// read goes straight to result. Reset sets width and height to 256 and radius to 0;
// the frame store is not cleared. A finished result waits in the output register;
// the sequencer holds its result only while that register is still full.
`default_nettype none

module block_pixelate_five_point_average_unit #(
    parameter int MAX_WIDTH    = bpfa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bpfa_pkg::DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = bpfa_pkg::DEF_CHANNEL_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] pos_x, [15:8] pos_y, [31:16] red_in, [47:32] green_in,
    // [63:48] blue_in, [79:64] extra_in
    input  wire logic [bpfa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] red_out, [31:16] green_out, [47:32] blue_out, [63:48] extra_out
    output logic [bpfa_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] outside_frame
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bpfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpfa_pkg::*;

    localparam int STORE_BITS  = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;
    localparam int MEM_W       = NUM_CHAN * STORE_BITS;
    localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NUM_SAMPLES = 5;
    localparam int SMP_W       = $clog2(NUM_SAMPLES);

    // Sample order within the mosaic square
    localparam logic [SMP_W-1:0] SMP_TOP_LEFT  = SMP_W'(0);
    localparam logic [SMP_W-1:0] SMP_TOP_RIGHT = SMP_W'(1);
    localparam logic [SMP_W-1:0] SMP_CENTER    = SMP_W'(2);
    localparam logic [SMP_W-1:0] SMP_BOT_LEFT  = SMP_W'(3);
    localparam logic [SMP_W-1:0] SMP_LAST      = SMP_W'(NUM_SAMPLES - 1);

    function automatic logic [DIM_W-1:0] clamp_pos(input logic [DIM_W:0]   v,
                                                   input logic [DIM_W-1:0] last);
        return (v > {1'b0, last}) ? last : v[DIM_W-1:0];
    endfunction

    // Configuration registers
    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [RADIUS_W-1:0] radius_reg;

    // Sequencer and request registers
    state_t              state_reg, state_next;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [RADIUS_W-1:0] r_reg;
    logic [DIM_W-1:0]    wlast_reg, hlast_reg;
    logic                outside_reg;
    logic [COORD_W-1:0]  tlx_reg, tly_reg;
    logic [DIM_W-1:0]    ccx_reg, ccy_reg, brx_reg, bry_reg;
    logic [SMP_W-1:0]    sample_cnt_reg, sample_cnt_next;
    logic                rd_valid_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_flag_reg;

    // Datapath nets
    logic [COORD_W-1:0]    pos_x, pos_y;
    logic                  accept, accept_read, accept_load, load_in_range;
    logic [DIM_W-1:0]      w_eff, h_eff;
    logic                  read_outside;
    logic [DIM_W-1:0]      side;
    logic                  div_done_x, div_done_y, div_done;
    logic [COORD_W-1:0]    rem_x, rem_y;
    logic [DIM_W-1:0]      smp_x, smp_y;
    logic                  mem_en, mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [MEM_W-1:0]      mem_wdata, mem_rdata;
    lane_ctrl_t            lane_ctrl;
    logic [STORE_BITS-1:0] lane_avg [NUM_CHAN];
    logic [OUT_TDATA_W-1:0] merged;
    logic                  result_load;

    assign pos_x = s_axis_tdata[IN_POS_X_LSB +: COORD_W];
    assign pos_y = s_axis_tdata[IN_POS_Y_LSB +: COORD_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign accept_read   = accept && (s_axis_tuser[0] == OP_READ);
    assign accept_load   = accept && (s_axis_tuser[0] == OP_LOAD);
    assign load_in_range = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);

    // Size in use, limited to the frame store
    assign w_eff = (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign read_outside = ({1'b0, pos_x} >= w_eff) || ({1'b0, pos_y} >= h_eff);
    assign side = {radius_reg, 1'b0};

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            radius_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_BLOCK_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Coordinate remainder lanes
    bpfa_rem_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept_read),
        .dividend  (pos_x),
        .divisor   (side),
        .done      (div_done_x),
        .remainder (rem_x)
    );

    bpfa_rem_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept_read),
        .dividend  (pos_y),
        .divisor   (side),
        .done      (div_done_y),
        .remainder (rem_y)
    );

    assign div_done = div_done_x && div_done_y;

    // Sequencer: next state and counters
    always_comb
    begin
        state_next      = state_reg;
        sample_cnt_next = sample_cnt_reg;
        result_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_cnt_next = '0;
                if (accept_read)
                begin
                    state_next = read_outside ? ST_RESULT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_CORNER;
                end
            end
            ST_CORNER: state_next = ST_CENTER;
            ST_CENTER: state_next = ST_EDGE;
            ST_EDGE:   state_next = ST_FETCH;
            ST_FETCH:
            begin
                sample_cnt_next = sample_cnt_reg + 1'b1;
                if (sample_cnt_reg == SMP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output register valid: set on result, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sample_cnt_reg <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sample_cnt_reg <= sample_cnt_next;
            rd_valid_reg   <= (state_reg == ST_FETCH);
            out_valid_reg  <= out_valid_next;
        end
    end

    // Latch request and derive sample coordinates one step per state
    always_ff @(posedge clk)
    begin
        if (accept_read)
        begin
            x_reg       <= pos_x;
            y_reg       <= pos_y;
            r_reg       <= radius_reg;
            wlast_reg   <= w_eff - 1'b1;
            hlast_reg   <= h_eff - 1'b1;
            outside_reg <= read_outside;
        end
        if (state_reg == ST_CORNER)
        begin
            tlx_reg <= (r_reg == '0) ? x_reg : x_reg - rem_x;
            tly_reg <= (r_reg == '0) ? y_reg : y_reg - rem_y;
        end
        if (state_reg == ST_CENTER)
        begin
            ccx_reg <= clamp_pos((DIM_W+1)'(tlx_reg) + (DIM_W+1)'(r_reg), wlast_reg);
            ccy_reg <= clamp_pos((DIM_W+1)'(tly_reg) + (DIM_W+1)'(r_reg), hlast_reg);
        end
        if (state_reg == ST_EDGE)
        begin
            brx_reg <= clamp_pos((DIM_W+1)'(ccx_reg) + (DIM_W+1)'(r_reg), wlast_reg);
            bry_reg <= clamp_pos((DIM_W+1)'(ccy_reg) + (DIM_W+1)'(r_reg), hlast_reg);
        end
    end

    // Select the sample to fetch
    always_comb
    begin
        case (sample_cnt_reg)
            SMP_TOP_LEFT:
            begin
                smp_x = DIM_W'(tlx_reg);
                smp_y = DIM_W'(tly_reg);
            end
            SMP_TOP_RIGHT:
            begin
                smp_x = brx_reg;
                smp_y = DIM_W'(tly_reg);
            end
            SMP_CENTER:
            begin
                smp_x = ccx_reg;
                smp_y = ccy_reg;
            end
            SMP_BOT_LEFT:
            begin
                smp_x = DIM_W'(tlx_reg);
                smp_y = bry_reg;
            end
            default:
            begin
                smp_x = brx_reg;
                smp_y = bry_reg;
            end
        endcase
    end

    // Frame store port: loads while idle, fetches during a read
    always_comb
    begin
        if (state_reg == ST_FETCH)
        begin
            mem_en   = 1'b1;
            mem_we   = 1'b0;
            mem_addr = ADDR_W'(32'(smp_y) * MAX_WIDTH + 32'(smp_x));
        end
        else
        begin
            mem_en   = accept_load && load_in_range;
            mem_we   = 1'b1;
            mem_addr = ADDR_W'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));
        end
    end

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_wdata
        assign mem_wdata[c*STORE_BITS +: STORE_BITS] =
            s_axis_tdata[IN_CHAN_LSB + c*CHAN_W +: STORE_BITS];
    end

    bpfa_frame_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Channel lanes
    assign lane_ctrl.clear      = accept_read;
    assign lane_ctrl.accumulate = rd_valid_reg;
    assign lane_ctrl.scale      = (state_reg == ST_SCALE);

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        bpfa_chan_lane #(
            .STORE_BITS (STORE_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .sample (mem_rdata[c*STORE_BITS +: STORE_BITS]),
            .avg    (lane_avg[c])
        );
        // Merge lane results; an outside read gives zero colours
        assign merged[c*CHAN_W +: CHAN_W] = outside_reg ? '0 : CHAN_W'(lane_avg[c]);
    end

    // Hold the merged result for the output side
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_data_reg <= merged;
            out_flag_reg <= outside_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_flag_reg;

endmodule

`default_nettype wire

>>> design/bpfa_checker.sv
// Port-level checker for the mosaic five-point average unit and its bind.
// Depends on bpfa_pkg and block_pixelate_five_point_average_unit.
`default_nettype none

module bpfa_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [0:0]                        s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [bpfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [0:0]                        m_axis_tuser
);
    import bpfa_pkg::*;

    // A stalled result keeps its valid and payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An outside read carries zero colours
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("outside read with nonzero colours");

    // A read request blocks further input while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_READ |=> !s_axis_tready)
        else $error("input taken during a read");

    // A load request leaves the input ready on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_LOAD |=> s_axis_tready)
        else $error("load stalled the input");

endmodule

bind block_pixelate_five_point_average_unit bpfa_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/block_pixelate_five_point_average_unit_checker.sv
// Checker for the mosaic five-point average unit: mirrors the frame store and
// the size and radius registers, predicts each read and compares the results.
// Depends on bpfa_pkg.
`timescale 1ns / 100ps

module block_pixelate_five_point_average_unit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // [7:0] pos_x, [15:8] pos_y, [31:16] red_in, [47:32] green_in,
    // [63:48] blue_in, [79:64] extra_in
    input  logic [bpfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] operation
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] red_out, [31:16] green_out, [47:32] blue_out, [63:48] extra_out
    input  logic [bpfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] outside_frame
    input  logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bpfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bpfa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatch_count,
    output int                                  results_outstanding
);
    import bpfa_pkg::*;

    localparam int FRAME_SIDE = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [OUT_TDATA_W-1:0] colors;
        logic                   outside;
    } pixel_result_t;

    // Shadow of the frame store, addressed as {pos_y, pos_x}
    logic [OUT_TDATA_W-1:0] frame_copy [0:FRAME_SIDE*DEF_MAX_HEIGHT-1];
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic [RADIUS_W-1:0]    radius_reg;
    pixel_result_t          pending_pixels [$];
    pixel_result_t          want;
    int                     mismatches = 0;
    int                     outstanding = 0;
    string                  lane_names [NUM_CHAN] =
        '{"red_out", "green_out", "blue_out", "extra_out"};

    assign mismatch_count      = mismatches;
    assign results_outstanding = outstanding;

    // Predict (px, py): outside flag, the pixel at radius zero, else mosaic five-tap average
    function automatic pixel_result_t censored_pixel(input logic [COORD_W-1:0] px,
                                                     input logic [COORD_W-1:0] py);
        pixel_result_t          res;
        int unsigned            w, h, r, side, tlx, tly, ccx, ccy, brx, bry, total;
        logic [OUT_TDATA_W-1:0] taps [5];
        res = '0;
        w = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
        h = (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
        r = radius_reg;
        if (px >= w || py >= h)
        begin
            res.outside = 1'b1;
            return res;
        end
        if (r == 0)
        begin
            res.colors = frame_copy[py * FRAME_SIDE + px];
            return res;
        end
        side = 2 * r;
        tlx  = (px / side) * side;
        tly  = (py / side) * side;
        ccx  = (tlx + r > w - 1) ? w - 1 : tlx + r;
        ccy  = (tly + r > h - 1) ? h - 1 : tly + r;
        brx  = (ccx + r > w - 1) ? w - 1 : ccx + r;
        bry  = (ccy + r > h - 1) ? h - 1 : ccy + r;
        taps[0] = frame_copy[tly * FRAME_SIDE + tlx];
        taps[1] = frame_copy[tly * FRAME_SIDE + brx];
        taps[2] = frame_copy[ccy * FRAME_SIDE + ccx];
        taps[3] = frame_copy[bry * FRAME_SIDE + tlx];
        taps[4] = frame_copy[bry * FRAME_SIDE + brx];
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            total = 0;
            for (int k = 0; k < 5; k++)
                total += taps[k][c*CHAN_W +: CHAN_W];
            // Round to nearest on the divide by five
            res.colors[c*CHAN_W +: CHAN_W] = CHAN_W'((total + 2) / 5);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [OUT_TDATA_W-1:0] exp_val,
                                 input logic [OUT_TDATA_W-1:0] got_val);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %h got %h", $time, field, exp_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 9'd256;
            height_reg = 9'd256;
            radius_reg = '0;
            pending_pixels.delete();
            outstanding <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    REG_BLOCK_RADIUS: radius_reg = cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end

            // Compare each result against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pixels.size() == 0)
                    note_mismatch("unrequested result", '0, m_axis_tdata);
                else
                begin
                    want = pending_pixels.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++)
                        if (m_axis_tdata[c*CHAN_W +: CHAN_W] !== want.colors[c*CHAN_W +: CHAN_W])
                            note_mismatch(lane_names[c], want.colors[c*CHAN_W +: CHAN_W],
                                          m_axis_tdata[c*CHAN_W +: CHAN_W]);
                    if (m_axis_tuser[0] !== want.outside)
                        note_mismatch("outside_frame", want.outside, m_axis_tuser[0]);
                end
            end

            // Apply loads to the shadow store, predict reads
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == OP_LOAD)
                    frame_copy[s_axis_tdata[IN_POS_Y_LSB +: COORD_W] * FRAME_SIDE
                               + s_axis_tdata[IN_POS_X_LSB +: COORD_W]]
                        = s_axis_tdata[IN_CHAN_LSB +: NUM_CHAN*CHAN_W];
                else
                    pending_pixels.push_back(censored_pixel(
                        s_axis_tdata[IN_POS_X_LSB +: COORD_W],
                        s_axis_tdata[IN_POS_Y_LSB +: COORD_W]));
            end

            outstanding <= pending_pixels.size();
        end
    end

endmodule

>>> tb/sv/block_pixelate_five_point_average_unit_test.sv
// Top of the mosaic five-point average unit test: clock, reset, load and read
// requests, register settings and receiver stalls; checking sits in the
// checker module. Depends on bpfa_pkg, the unit and its checker.
`timescale 1ns / 100ps

module block_pixelate_five_point_average_unit_test;
    import bpfa_pkg::*;

    localparam int                     FRAME_SIDE   = DEF_MAX_WIDTH;
    localparam int                     RANDOM_ITEMS = 550;
    localparam int                     SETTLE_TICKS = 20;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE    = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // [7:0] pos_x, [15:8] pos_y, [31:16] red_in, [47:32] green_in,
    // [63:48] blue_in, [79:64] extra_in
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    // [0] operation
    logic [0:0]                 s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // [15:0] red_out, [31:16] green_out, [47:32] blue_out, [63:48] extra_out
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    // [0] outside_frame
    logic [0:0]                 m_axis_tuser;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    int                         mismatch_count;
    int                         results_outstanding;

    // Stimulus bookkeeping
    bit                         loaded [0:FRAME_SIDE*DEF_MAX_HEIGHT-1];
    int unsigned                cur_width  = 256;
    int unsigned                cur_height = 256;
    int unsigned                cur_radius = 0;
    int                         items_sent = 0;
    int                         loads_sent = 0;
    int                         reads_sent = 0;
    int                         outside_reads = 0;
    int                         settings_used = 1;
    int                         calm_left = 0;
    bit                         squeeze_req = 0;

    block_pixelate_five_point_average_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    block_pixelate_five_point_average_unit_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the unit hangs
    initial
    begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned eff_width();
        return (cur_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cur_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_height;
    endfunction

    // Channel values lean toward the extremes now and then
    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] random_pixel();
        return {random_channel(), random_channel(), random_channel(), random_channel()};
    endfunction

    // Mostly short gaps, some long, with stretches of none
    function automatic int idle_gap();
        int pick;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_item(input logic op, input int unsigned px, input int unsigned py,
                             input logic [OUT_TDATA_W-1:0] chans);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {chans, COORD_W'(py), COORD_W'(px)};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (op == OP_LOAD)
        begin
            loads_sent++;
            loaded[py * FRAME_SIDE + px] = 1'b1;
        end
        else
            reads_sent++;
    endtask

    // Load whatever taps the read depends on, then read
    task automatic read_pixel(input int unsigned px, input int unsigned py);
        int unsigned xs [5];
        int unsigned ys [5];
        int unsigned side, tlx, tly, ccx, ccy, brx, bry, w, h, r;
        int          n;
        w = eff_width();
        h = eff_height();
        r = cur_radius;
        n = 0;
        if (px < w && py < h)
        begin
            if (r == 0)
            begin
                xs[0] = px;
                ys[0] = py;
                n = 1;
            end
            else
            begin
                side = 2 * r;
                tlx  = (px / side) * side;
                tly  = (py / side) * side;
                ccx  = (tlx + r > w - 1) ? w - 1 : tlx + r;
                ccy  = (tly + r > h - 1) ? h - 1 : tly + r;
                brx  = (ccx + r > w - 1) ? w - 1 : ccx + r;
                bry  = (ccy + r > h - 1) ? h - 1 : ccy + r;
                xs = '{tlx, brx, ccx, tlx, brx};
                ys = '{tly, tly, ccy, bry, bry};
                n = 5;
            end
        end
        else
            outside_reads++;
        for (int k = 0; k < n; k++)
            if (!loaded[ys[k] * FRAME_SIDE + xs[k]])
                send_item(OP_LOAD, xs[k], ys[k], random_pixel());
        send_item(OP_READ, px, py, random_pixel());
    endtask

    // Drop valid and wait until every result is back and the unit is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_outstanding != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  cur_width  = value;
            REG_IMAGE_HEIGHT: cur_height = value;
            REG_BLOCK_RADIUS: cur_radius = value[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
                                input logic [CFG_DATA_W-1:0] rv, input bit poke_spare);
        settle();
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_BLOCK_RADIUS, rv);
        if (poke_spare)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return 9'd1;
            1:       return 9'd2;
            2:       return 9'd256;
            3:       return CFG_DATA_W'($urandom_range(257, 511));
            4:       return 9'd0;
            default: return CFG_DATA_W'($urandom_range(3, 24));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_radius();
        logic [RADIUS_W-1:0] r8;
        case ($urandom_range(0, 7))
            0:       r8 = 8'd0;
            1:       r8 = 8'd128;
            2:       r8 = 8'd255;
            3:       r8 = 8'd1;
            default: r8 = RADIUS_W'($urandom_range(2, 12));
        endcase
        // Bit 8 is dropped by the register
        return {1'($urandom_range(0, 1)), r8};
    endfunction

    // Receiver: random stalls plus one long hold-off on request
    initial
    begin
        int          hold_cycles;
        int          pick;
        logic        ready_level;
        hold_cycles   = 0;
        ready_level   = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
                hold_cycles--;
            else if (squeeze_req)
            begin
                squeeze_req = 0;
                ready_level = 1'b0;
                hold_cycles = 250;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    ready_level = 1'b1;
                    hold_cycles = $urandom_range(0, 12);
                end
                else if (pick < 60)
                begin
                    ready_level = 1'b1;
                    hold_cycles = $urandom_range(40, 80);
                end
                else if (pick < 92)
                begin
                    ready_level = 1'b0;
                    hold_cycles = $urandom_range(0, 3);
                end
                else
                begin
                    ready_level = 1'b0;
                    hold_cycles = $urandom_range(10, 50);
                end
            end
            m_axis_tready <= ready_level;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int  directed_items;
        int  phase_len;
        int  pick;
        int unsigned px, py, w, h;
        bit  squeezed;
        squeezed      = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners of the full frame, passed straight through at radius zero
        send_item(OP_LOAD, 0, 0, '0);
        send_item(OP_LOAD, 255, 255, '1);
        send_item(OP_LOAD, 255, 0, {4{16'h5555}});
        send_item(OP_LOAD, 0, 255, {4{16'hAAAA}});
        read_pixel(0, 0);
        read_pixel(255, 255);
        read_pixel(255, 0);
        read_pixel(0, 255);

        // Smallest mosaic, all taps at full scale, reads just past the edge
        program_regs(9'd2, 9'd2, 9'd1, 0);
        send_item(OP_LOAD, 0, 0, '1);
        send_item(OP_LOAD, 1, 0, '1);
        send_item(OP_LOAD, 0, 1, '1);
        send_item(OP_LOAD, 1, 1, '1);
        read_pixel(1, 1);
        read_pixel(2, 0);
        read_pixel(0, 2);

        // Zero width, oversized height, radius with the dropped top bit
        program_regs(9'd0, 9'd300, 9'h105, 1);
        read_pixel(0, 0);

        // Oversized width and a radius far beyond the frame
        program_regs(9'd511, 9'd256, 9'd255, 0);
        read_pixel(200, 100);
        read_pixel(255, 255);

        // Half-frame radius
        program_regs(9'd256, 9'd256, 9'd128, 0);
        read_pixel(129, 130);
        directed_items = items_sent;

        // Random phases, each under a new register setting
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            program_regs(random_size(), random_size(), random_radius(),
                         $urandom_range(0, 3) == 0);
            w = eff_width();
            h = eff_height();
            phase_len = $urandom_range(30, 70);
            for (int k = 0; k < phase_len && items_sent < directed_items + RANDOM_ITEMS; k++)
            begin
                // Stall the receiver for a long stretch while requests keep coming
                if (!squeezed && items_sent >= directed_items + 250)
                begin
                    squeezed    = 1;
                    squeeze_req = 1;
                    calm_left   = 80;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    px = (w == 0) ? $urandom_range(0, 255) : $urandom_range(0, w - 1);
                    py = (h == 0) ? $urandom_range(0, 255) : $urandom_range(0, h - 1);
                    read_pixel(px, py);
                end
                else if (pick < 85)
                    send_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                              random_pixel());
                else
                begin
                    px = $urandom_range(0, 255);
                    py = $urandom_range(0, 255);
                    if (w < DEF_MAX_WIDTH)
                        px = $urandom_range(w, 255);
                    else if (h < DEF_MAX_HEIGHT)
                        py = $urandom_range(h, 255);
                    read_pixel(px, py);
                end
            end
        end

        settle();
        $display("Sent %0d loads and %0d reads (%0d outside the frame) under %0d settings,",
                 loads_sent, reads_sent, outside_reads, settings_used);
        $display("including extreme sizes and radii and one long output stall.");
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> block_pixelate_five_point_average_unit.f
design/bpfa_pkg.sv
design/bpfa_rem_div.sv
design/bpfa_chan_lane.sv
design/bpfa_frame_mem.sv
design/block_pixelate_five_point_average_unit.sv
design/bpfa_checker.sv
tb/sv/block_pixelate_five_point_average_unit_checker.sv
tb/sv/block_pixelate_five_point_average_unit_test.sv
